/* sv/faddftz_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faddftz_pkg
// Constants for the single-precision adder with denormals flushed to zero.
// ----------------------------------------------------------------------------
package faddftz_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned EXP_W  = 8;
   localparam int unsigned FRAC_W = 23;
   // hidden one, fraction, guard, round, sticky
   localparam int unsigned SIG_W  = 27;
   // signed working exponent
   localparam int unsigned EW_W   = 10;
   localparam int unsigned GAP_W  = 5;
   localparam int unsigned LZ_W   = 5;

   localparam logic [WORD_W-1:0] NAN_WORD  = 32'hfff00000;
   localparam logic [WORD_W-1:0] MAG_MASK  = 32'h7fffffff;
   localparam logic [WORD_W-1:0] INF_BITS  = 32'h7f800000;
   localparam logic [EXP_W-1:0]  EXP_MAX   = 8'hff;
   localparam logic [EXP_W-1:0]  GAP_LIMIT = 8'd26;
   localparam logic [LZ_W-1:0]   LZ_LIMIT  = 5'd26;

endpackage

/* sv/float32_adder_flush_to_zero.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_adder_flush_to_zero
// Four-stage pipelined IEEE-754 single adder, denormals read as zero,
// round to nearest even.
// ----------------------------------------------------------------------------
// Results pass through four register stages (decode, align/add, normalize,
// round) from start to rsp_strobe. Throughput: one word per cycle.
// busy is always low; the receiver cannot stall, so the pipe never holds.
// Reset (synchronous, active high) clears the stage valid bits only.
module float32_adder_flush_to_zero (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [faddftz_pkg::WORD_W-1:0]  req_operand_a,
   input  logic [faddftz_pkg::WORD_W-1:0]  req_operand_b,
   output logic                            rsp_strobe,
   output logic [faddftz_pkg::WORD_W-1:0]  rsp_sum_word
);
   import faddftz_pkg::*;

   // stage 1 registers
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_spec_ff, s1_spec_in;
   logic [WORD_W-1:0]       s1_word_ff, s1_word_in;
   logic                    s1_sign_ff, s1_sign_in;
   logic                    s1_sub_ff, s1_sub_in;
   logic [EXP_W-1:0]        s1_exp_ff, s1_exp_in;
   logic [FRAC_W-1:0]       s1_fl_ff, s1_fl_in;
   logic [FRAC_W-1:0]       s1_fs_ff, s1_fs_in;
   logic [GAP_W-1:0]        s1_gap_ff, s1_gap_in;

   // stage 2 registers
   logic                    s2_valid_ff;
   logic                    s2_spec_ff;
   logic [WORD_W-1:0]       s2_word_ff;
   logic                    s2_sign_ff;
   logic                    s2_sub_ff;
   logic signed [EW_W-1:0]  s2_exp_ff, s2_exp_in;
   logic [SIG_W-1:0]        s2_sig_ff, s2_sig_in;

   // stage 3 registers
   logic                    s3_valid_ff;
   logic                    s3_spec_ff, s3_spec_in;
   logic [WORD_W-1:0]       s3_word_ff, s3_word_in;
   logic                    s3_sign_ff;
   logic signed [EW_W-1:0]  s3_exp_ff, s3_exp_in;
   logic [SIG_W-1:0]        s3_sig_ff, s3_sig_in;

   // output registers
   logic                    out_strobe_ff;
   logic [WORD_W-1:0]       out_word_ff, out_word_in;

   assign busy = 1'b0;

   // ---- stage 1: special cases, magnitude order, exponent gap ----
   logic [EXP_W-1:0]  exp_a, exp_b, exp_l, exp_s, gap_full;
   logic [FRAC_W-1:0] frac_a, frac_b;
   logic              nan_a, nan_b, inf_a, inf_b, swap;
   logic [WORD_W-1:0] large_w, small_w;

   always_comb begin
      exp_a  = req_operand_a[WORD_W-2 -: EXP_W];
      exp_b  = req_operand_b[WORD_W-2 -: EXP_W];
      frac_a = req_operand_a[FRAC_W-1:0];
      frac_b = req_operand_b[FRAC_W-1:0];
      nan_a  = (exp_a == EXP_MAX) && (frac_a != '0);
      nan_b  = (exp_b == EXP_MAX) && (frac_b != '0);
      inf_a  = (exp_a == EXP_MAX) && (frac_a == '0);
      inf_b  = (exp_b == EXP_MAX) && (frac_b == '0);
      swap   = (req_operand_a & MAG_MASK) > (req_operand_b & MAG_MASK);
      large_w = swap ? req_operand_a : req_operand_b;
      small_w = swap ? req_operand_b : req_operand_a;
      exp_l   = large_w[WORD_W-2 -: EXP_W];
      exp_s   = small_w[WORD_W-2 -: EXP_W];
      gap_full = exp_l - exp_s;

      s1_valid_in = start;
      s1_spec_in  = 1'b1;
      s1_word_in  = large_w;
      priority if (nan_a || nan_b) begin
         s1_word_in = NAN_WORD;
      end else if (inf_a && inf_b) begin
         s1_word_in = (req_operand_a[WORD_W-1] == req_operand_b[WORD_W-1]) ?
                      req_operand_a : NAN_WORD;
      end else if (inf_a) begin
         s1_word_in = req_operand_a;
      end else if (inf_b) begin
         s1_word_in = req_operand_b;
      end else if (exp_a == '0 && exp_b == '0) begin
         s1_word_in = '0;
      end else if (exp_a == '0) begin
         s1_word_in = req_operand_b;
      end else if (exp_b == '0) begin
         s1_word_in = req_operand_a;
      end else if (gap_full >= GAP_LIMIT) begin
         s1_word_in = large_w;
      end else begin
         s1_spec_in = 1'b0;
      end
      s1_sign_in = large_w[WORD_W-1];
      s1_sub_in  = large_w[WORD_W-1] != small_w[WORD_W-1];
      s1_exp_in  = exp_l;
      s1_fl_in   = large_w[FRAC_W-1:0];
      s1_fs_in   = small_w[FRAC_W-1:0];
      s1_gap_in  = gap_full[GAP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_spec_ff <= s1_spec_in;
      s1_word_ff <= s1_word_in;
      s1_sign_ff <= s1_sign_in;
      s1_sub_ff  <= s1_sub_in;
      s1_exp_ff  <= s1_exp_in;
      s1_fl_ff   <= s1_fl_in;
      s1_fs_ff   <= s1_fs_in;
      s1_gap_ff  <= s1_gap_in;
   end

   // ---- stage 2: align smaller operand with sticky, add or subtract ----
   logic [SIG_W-1:0] fs_w, fl_w, fs_sh, lost_mask;
   logic             sticky;
   logic [SIG_W:0]   sum_w;

   always_comb begin
      fs_w      = {1'b1, s1_fs_ff, 3'b000};
      fl_w      = {1'b1, s1_fl_ff, 3'b000};
      lost_mask = ~({SIG_W{1'b1}} << s1_gap_ff);
      sticky    = |(fs_w & lost_mask);
      fs_sh     = fs_w >> s1_gap_ff;
      s2_exp_in = signed'({{(EW_W-EXP_W){1'b0}}, s1_exp_ff});
      if (s1_sub_ff) begin
         sum_w     = {1'b0, fl_w} - {1'b0, fs_sh | {{(SIG_W-1){1'b0}}, sticky}};
         s2_sig_in = sum_w[SIG_W-1:0];
      end else begin
         sum_w = ({1'b0, fs_sh} + {1'b0, fl_w}) | {{SIG_W{1'b0}}, sticky};
         if (sum_w[SIG_W]) begin
            s2_exp_in = s2_exp_in + EW_W'(1);
            s2_sig_in = sum_w[SIG_W:1] | {{(SIG_W-1){1'b0}}, sum_w[0]};
         end else begin
            s2_sig_in = sum_w[SIG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_spec_ff <= s1_spec_ff;
      s2_word_ff <= s1_word_ff;
      s2_sign_ff <= s1_sign_ff;
      s2_sub_ff  <= s1_sub_ff;
      s2_exp_ff  <= s2_exp_in;
      s2_sig_ff  <= s2_sig_in;
   end

   // ---- stage 3: leading-zero count and normalize after subtraction ----
   logic [LZ_W-1:0] lz;
   logic            lz_found;

   always_comb begin
      lz       = LZ_W'(SIG_W);
      lz_found = 1'b0;
      for (int i = SIG_W-1; i >= 0; i--) begin
         if (!lz_found && s2_sig_ff[i]) begin
            lz       = LZ_W'(SIG_W-1-i);
            lz_found = 1'b1;
         end
      end
      s3_spec_in = s2_spec_ff;
      s3_word_in = s2_word_ff;
      s3_exp_in  = s2_exp_ff;
      s3_sig_in  = s2_sig_ff;
      if (!s2_spec_ff && s2_sub_ff) begin
         if (lz >= LZ_LIMIT) begin
            // exact cancellation gives +0
            s3_spec_in = 1'b1;
            s3_word_in = '0;
         end else begin
            s3_sig_in = s2_sig_ff << lz;
            s3_exp_in = s2_exp_ff - signed'({{(EW_W-LZ_W){1'b0}}, lz});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_spec_ff <= s3_spec_in;
      s3_word_ff <= s3_word_in;
      s3_sign_ff <= s2_sign_ff;
      s3_exp_ff  <= s3_exp_in;
      s3_sig_ff  <= s3_sig_in;
   end

   // ---- stage 4: round to nearest even, range check, pack ----
   logic [SIG_W:0]         rnd;
   logic [SIG_W-1:0]       sig_r;
   logic signed [EW_W-1:0] exp_r;

   always_comb begin
      rnd   = {1'b0, s3_sig_ff};
      exp_r = s3_exp_ff;
      if (s3_sig_ff[2] && (s3_sig_ff[3] || s3_sig_ff[1] || s3_sig_ff[0])) begin
         rnd = rnd + (SIG_W+1)'(8);
      end
      if (rnd[SIG_W]) begin
         exp_r = exp_r + EW_W'(1);
         sig_r = rnd[SIG_W:1];
      end else begin
         sig_r = rnd[SIG_W-1:0];
      end
      priority if (s3_spec_ff) begin
         out_word_in = s3_word_ff;
      end else if (exp_r >= signed'(EW_W'(255))) begin
         out_word_in = {s3_sign_ff, 31'b0} | INF_BITS;
      end else if (exp_r <= signed'(EW_W'(0))) begin
         out_word_in = {s3_sign_ff, 31'b0};
      end else begin
         out_word_in = {s3_sign_ff, exp_r[EXP_W-1:0], sig_r[FRAC_W+2:3]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= s3_valid_ff;
      end
      out_word_ff <= out_word_in;
   end

   assign rsp_strobe   = out_strobe_ff;
   assign rsp_sum_word = out_word_ff;

endmodule
